/* rtl/agl_pkg.sv */
`timescale 1ns / 1ps

package agl_pkg;

	localparam int GAIN_FRAC_BITS_DEF = 6;
	localparam int SAMPLE_W           = 24;
	localparam int OUT_W              = 16;
	localparam int CLIP_W             = 15;
	localparam int GAIN_RESET         = 16;
	localparam logic [CLIP_W-1:0] CLIP_RESET = 15'd32737;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_EVAL,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic eval;
		logic div_step;
		logic gain_upd;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clip;
		logic div_done;
	} status_t;

endpackage

/* rtl/agl_ctrl.sv */
`timescale 1ns / 1ps

module agl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  agl_pkg::status_t  status,
	output agl_pkg::cmd_t     cmd
);

	agl_pkg::state_t state_q, state_nxt;
	logic            out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= agl_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			out_valid_q <= cmd.out_load | (out_valid_q & out_stall);
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			agl_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = agl_pkg::ST_MUL;
				end
			end
			agl_pkg::ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = agl_pkg::ST_EVAL;
			end
			agl_pkg::ST_EVAL: begin
				cmd.eval  = 1'b1;
				state_nxt = status.clip ? agl_pkg::ST_DIV : agl_pkg::ST_DONE;
			end
			agl_pkg::ST_DIV: begin
				if (status.div_done) begin
					cmd.gain_upd = 1'b1;
					state_nxt    = agl_pkg::ST_DONE;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			agl_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_nxt    = agl_pkg::ST_IDLE;
				end
			end
			default: state_nxt = agl_pkg::ST_IDLE;
		endcase
	end

	assign in_stall  = (state_q != agl_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

/* rtl/agl_datapath.sv */
`timescale 1ns / 1ps

module agl_datapath #(
	parameter int GAIN_FRAC_BITS = agl_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_wr_en,
	input  logic        [agl_pkg::CLIP_W-1:0]       cfg_wr_data,
	input  logic signed [agl_pkg::SAMPLE_W-1:0]     mix_sample,
	input  logic                                    block_start,
	output logic signed [agl_pkg::OUT_W-1:0]        out_sample,
	output logic                                    clipped,
	input  agl_pkg::cmd_t                           cmd,
	output agl_pkg::status_t                        status
);

	localparam int F  = GAIN_FRAC_BITS;
	localparam int XW = agl_pkg::SAMPLE_W;
	localparam int OW = agl_pkg::OUT_W;
	localparam int LW = agl_pkg::CLIP_W;
	localparam int GW = F + 1;
	localparam int PW = XW + GW + 1;
	localparam int SW = PW - F;
	localparam int NW = LW + F;
	localparam int CW = $clog2(NW + 1);
	localparam logic [GW-1:0] UNITY = GW'(1) << F;

	logic signed [XW-1:0] sample_q;
	logic        [GW-1:0] gain_q;
	logic        [LW-1:0] clip_q;
	logic signed [PW-1:0] prod_s1;
	logic        [OW-1:0] res_q;
	logic                 clip_flag_q;
	logic        [XW-1:0] rem_q;
	logic        [XW-1:0] mag_q;
	logic        [NW-1:0] quot_q;
	logic        [CW-1:0] cnt_q;
	logic signed [OW-1:0] out_sample_q;
	logic                 clipped_q;

	logic signed [SW-1:0] scaled;
	logic signed [SW-1:0] clip_ext;
	logic                 over;
	logic        [OW-1:0] res_nxt;
	logic        [XW-1:0] mag;
	logic        [XW:0]   shifted;
	logic        [XW:0]   diff;
	logic                 ge;
	logic                 gain_bump;

	assign gain_bump = block_start && (gain_q < UNITY);
	assign scaled    = SW'(prod_s1 >>> F);
	assign clip_ext  = signed'(SW'(clip_q));
	assign over      = (scaled > clip_ext) || (scaled < -clip_ext);

	always_comb begin
		if (!over) begin
			res_nxt = scaled[OW-1:0];
		end else if (scaled[SW-1]) begin
			res_nxt = -{1'b0, clip_q};
		end else begin
			res_nxt = {1'b0, clip_q};
		end
	end

	assign mag     = sample_q[XW-1] ? (~sample_q + XW'(1)) : sample_q;
	assign shifted = {rem_q, quot_q[NW-1]};
	assign ge      = (shifted >= {1'b0, mag_q});
	assign diff    = shifted - {1'b0, mag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GW'(agl_pkg::GAIN_RESET);
			clip_q <= agl_pkg::CLIP_RESET;
		end else begin
			if (cfg_wr_en) begin
				clip_q <= cfg_wr_data;
			end
			if (cmd.load) begin
				gain_q <= gain_q + GW'(gain_bump);
			end else if (cmd.gain_upd) begin
				gain_q <= quot_q[GW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= mix_sample;
		end
		if (cmd.mul) begin
			prod_s1 <= sample_q * signed'({1'b0, gain_q});
		end
		if (cmd.eval) begin
			res_q       <= res_nxt;
			clip_flag_q <= over;
			rem_q       <= '0;
			mag_q       <= mag;
			quot_q      <= {clip_q, F'(0)};
			cnt_q       <= CW'(NW);
		end else if (cmd.div_step) begin
			rem_q  <= ge ? diff[XW-1:0] : shifted[XW-1:0];
			quot_q <= {quot_q[NW-2:0], ge};
			cnt_q  <= cnt_q - CW'(1);
		end
		if (cmd.out_load) begin
			out_sample_q <= signed'(res_q);
			clipped_q    <= clip_flag_q;
		end
	end

	assign status.clip     = over;
	assign status.div_done = (cnt_q == '0);
	assign out_sample      = out_sample_q;
	assign clipped         = clipped_q;

endmodule

/* rtl/adaptive_gain_limiter_unit.sv */
`timescale 1ns / 1ps
// Adaptive gain limiter.
// Input channel: mix_sample (24-bit signed) with block_start, transfer on
// in_valid high and in_stall low. Output channel: out_sample (16-bit signed)
// and clipped, transfer on out_valid high and out_stall low. One result per
// input transfer, in order.
// clip_level is written through cfg_wr_en / cfg_wr_data; the user must do
// so only while the block is idle, which the block itself does not enforce.
// It takes effect from the next input transfer. An input transfer loads
// the sample, then the block multiplies it by the gain, evaluates the clip
// and loads the output register; a sample that clips first passes through the
// one-bit-per-cycle restoring divider that recomputes the gain. One item
// is in flight at a time; the next input transfer is taken once the
// previous result has moved into the output register.
// A result held under out_stall stays stable; the next item may be taken
// meanwhile but is held in the datapath until the output register frees.
// Reset (arst_n low, asynchronous): gain returns to 16, clip_level to
// 32737, the output register empties and the controller returns to idle.
module adaptive_gain_limiter_unit #(
	parameter int GAIN_FRAC_BITS = agl_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic        [agl_pkg::CLIP_W-1:0]   cfg_wr_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [agl_pkg::SAMPLE_W-1:0] mix_sample,
	input  logic                                block_start,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [agl_pkg::OUT_W-1:0]    out_sample,
	output logic                                clipped
);

	agl_pkg::cmd_t    cmd;
	agl_pkg::status_t status;

	agl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	agl_datapath #(
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.mix_sample  (mix_sample),
		.block_start (block_start),
		.out_sample  (out_sample),
		.clipped     (clipped),
		.cmd         (cmd),
		.status      (status)
	);

endmodule

/* rtl/agl_checker.sv */
`timescale 1ns / 1ps

module agl_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [agl_pkg::OUT_W-1:0]    out_sample,
	input logic                                clipped
);

	logic in_xfer;
	assign in_xfer = in_valid && !in_stall;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_sample) && $stable(clipped))
		else $error("result changed while stalled");

	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> in_stall)
		else $error("input taken while an item is in flight");

	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && !out_valid |=> !out_valid ##1 !out_valid)
		else $error("result appeared too early");

	a_no_min_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_sample != 16'sh8000)
		else $error("output outside symmetric range");

endmodule

bind adaptive_gain_limiter_unit agl_checker u_agl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.out_sample (out_sample),
	.clipped    (clipped)
);

/* tb/sv/adaptive_gain_limiter_unit_test.sv */
`timescale 1ns / 1ps

module adaptive_gain_limiter_unit_test;

	localparam int GAIN_FRAC = agl_pkg::GAIN_FRAC_BITS_DEF;
	localparam int GAIN_W    = GAIN_FRAC + 1;
	localparam int UNITY     = 1 << GAIN_FRAC;
	localparam int SETTLE    = 40;
	localparam int EXP_AW    = 12;
	localparam int EXP_DEPTH = 1 << EXP_AW;

	typedef struct {
		logic signed [agl_pkg::OUT_W-1:0] sample;
		logic                             clip_hit;
	} limited_sample_t;

	logic                                clk         = 1'b0;
	logic                                arst_n      = 1'b0;
	logic                                cfg_wr_en   = 1'b0;
	logic        [agl_pkg::CLIP_W-1:0]   cfg_wr_data = '0;
	logic                                in_valid    = 1'b0;
	logic                                in_stall;
	logic signed [agl_pkg::SAMPLE_W-1:0] mix_sample  = '0;
	logic                                block_start = 1'b0;
	logic                                out_valid;
	logic                                out_stall   = 1'b0;
	logic signed [agl_pkg::OUT_W-1:0]    out_sample;
	logic                                clipped;

	logic [GAIN_W-1:0]         gain_now = GAIN_W'(agl_pkg::GAIN_RESET);
	logic [agl_pkg::CLIP_W-1:0] clip_now = agl_pkg::CLIP_RESET;
	limited_sample_t           expected_mem[EXP_DEPTH];
	int                        exp_wr      = 0;
	int                        exp_rd      = 0;
	limited_sample_t           head;
	int                        error_count = 0;
	int                        out_count   = 0;
	int                        stall_left  = 0;
	bit                        no_idle     = 1'b0;

	adaptive_gain_limiter_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mix_sample  (mix_sample),
		.block_start (block_start),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_sample  (out_sample),
		.clipped     (clipped)
	);

	always #5 clk = ~clk;

	initial begin
		#10_000_000;
		$display("adaptive_gain_limiter_unit_test failed");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at output %0d: %s", out_count, msg);
		error_count++;
	endtask

	// block-start recovery, scale with floor, saturate and recompute the gain
	function automatic limited_sample_t apply_gain(input logic signed [23:0] x, input logic bs);
		longint          scaled;
		longint          lim;
		longint          mag;
		limited_sample_t r;
		if (bs && gain_now < GAIN_W'(UNITY))
			gain_now = gain_now + 1'b1;
		scaled = (longint'(x) * longint'(gain_now)) >>> GAIN_FRAC;
		lim = longint'(clip_now);
		r.clip_hit = 1'b0;
		if (scaled > lim || scaled < -lim) begin
			mag = (x < 0) ? -longint'(x) : longint'(x);
			gain_now = GAIN_W'((lim << GAIN_FRAC) / mag);
			scaled = (scaled < 0) ? -lim : lim;
			r.clip_hit = 1'b1;
		end
		r.sample = agl_pkg::OUT_W'(scaled);
		return r;
	endfunction

	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [23:0] rand_sample();
		int unsigned            pick;
		logic signed [23:0]     v;
		pick = $urandom_range(0, 9);
		case (pick)
			0, 1, 2: v = 24'($urandom_range(0, 2000));
			3, 4, 5: v = 24'($urandom_range(0, 4 * clip_now + 64));
			6, 7, 8: v = 24'($urandom);
			default: begin
				case ($urandom_range(0, 4))
					0: v = 24'sh7FFFFF;
					1: v = 24'sh800000;
					2: v = 24'sd0;
					3: v = 24'sd1;
					default: v = -24'sd1;
				endcase
			end
		endcase
		if (pick < 6 && $urandom_range(0, 1) == 1)
			v = -v;
		return v;
	endfunction

	// called at a rising edge; returns at the edge of the transfer
	task automatic send_sample(input logic signed [23:0] x, input logic bs);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		mix_sample  <= x;
		block_start <= bs;
		do @(posedge clk); while (in_stall);
		expected_mem[EXP_AW'(exp_wr)] = apply_gain(x, bs);
		exp_wr++;
	endtask

	task automatic drain_outputs();
		in_valid <= 1'b0;
		do @(posedge clk); while (exp_wr != exp_rd);
	endtask

	task automatic write_clip(input logic [agl_pkg::CLIP_W-1:0] v);
		drain_outputs();
		repeat (SETTLE) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		clip_now = v;
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (!no_idle && $urandom_range(0, 99) < 20) begin
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (exp_wr == exp_rd) begin
				report_mismatch($sformatf("transfer with nothing expected, out_sample %0d",
					out_sample));
			end else begin
				head = expected_mem[EXP_AW'(exp_rd)];
				exp_rd++;
				if (out_sample !== head.sample)
					report_mismatch($sformatf("out_sample %0d, want %0d", out_sample, head.sample));
				if (clipped !== head.clip_hit)
					report_mismatch($sformatf("clipped %b, want %b", clipped, head.clip_hit));
			end
			out_count++;
		end
	end

	// reset clip level: small values, full-scale clip drives gain to zero, recovery
	task automatic test_gain_collapse_and_recovery();
		send_sample(24'sd0, 1'b0);
		send_sample(24'sd1, 1'b0);
		send_sample(-24'sd1, 1'b0);
		send_sample(24'sd100000, 1'b1);
		send_sample(24'sh7FFFFF, 1'b0);
		send_sample(24'sh800000, 1'b1);
		send_sample(24'sd100, 1'b0);
		send_sample(24'sd1000, 1'b1);
		send_sample(-24'sd1000, 1'b1);
		send_sample(24'sd1000, 1'b1);
	endtask

	// zero clip level: any nonzero scaled sample clips to zero
	task automatic test_clip_level_zero();
		write_clip('0);
		send_sample(24'sd0, 1'b1);
		send_sample(24'sd1, 1'b0);
		send_sample(-24'sd1, 1'b0);
		send_sample(24'sd5000, 1'b1);
	endtask

	task automatic test_clip_level_extremes();
		write_clip('1);
		send_sample(24'sh7FFFFF, 1'b1);
		send_sample(24'sh800000, 1'b1);
		write_clip(15'd1);
		send_sample(24'sd64, 1'b1);
		send_sample(-24'sd64, 1'b0);
		send_sample(24'sd128, 1'b0);
		send_sample(24'sh7FFFFF, 1'b0);
	endtask

	// mostly well-formed blocks, some stray samples; one clip level per phase
	task automatic test_random_blocks();
		logic [agl_pkg::CLIP_W-1:0] lvl;
		int                         sent;
		int                         len;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: lvl = '1;
				1: lvl = 15'd1;
				3: lvl = '0;
				4: lvl = 15'($urandom_range(100, 2000));
				5: lvl = agl_pkg::CLIP_RESET;
				7: lvl = 15'($urandom_range(1, 255));
				default: lvl = 15'($urandom_range(1, 32767));
			endcase
			write_clip(lvl);
			no_idle = (phase % 3 == 1);
			sent = 0;
			while (sent < 204) begin
				if ($urandom_range(0, 9) == 0) begin
					send_sample(rand_sample(), 1'($urandom_range(0, 1)));
					sent++;
				end else begin
					len = $urandom_range(1, 12);
					for (int k = 0; k < len; k++)
						send_sample(rand_sample(), k == 0);
					sent += len;
				end
				if (sent >= 100 && sent < 100 + 13 && $urandom_range(0, 3) == 0)
					drain_outputs();
			end
			no_idle = 1'b0;
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_gain_collapse_and_recovery();
		test_clip_level_zero();
		test_clip_level_extremes();
		test_random_blocks();
		drain_outputs();
		repeat (SETTLE) @(posedge clk);
		if (exp_wr != exp_rd)
			report_mismatch($sformatf("%0d results never arrived", exp_wr - exp_rd));
		if (error_count == 0) begin
			$display("adaptive_gain_limiter_unit_test passed");
		end else begin
			$display("adaptive_gain_limiter_unit_test failed");
		end
		$finish;
	end

endmodule
